// ===== src/load_cell_force_conditioner_top_defines.svh =====
// ---------------------------------------------------------------------------
// load cell force conditioner assertion macros
// shared concurrent assertion forms for the conditioner rtl
// ---------------------------------------------------------------------------
`ifndef LOAD_CELL_FORCE_CONDITIONER_TOP_DEFINES_SVH
`define LOAD_CELL_FORCE_CONDITIONER_TOP_DEFINES_SVH

// property checked at every clock edge outside reset
`define LCFC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define LCFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

// ===== src/lcfc_pkg.sv =====
// ---------------------------------------------------------------------------
// lcfc_pkg
// widths, codes, reset values and shared types of the force conditioner
// ---------------------------------------------------------------------------
package lcfc_pkg;

   // default parameter values
   localparam int DEF_ADC_BITS  = 24;
   localparam int DEF_FRAC_BITS = 16;

   // fixed field widths
   localparam int ACTION_W   = 2;
   localparam int STATUS_W   = 3;
   localparam int FORCE_W    = 32;
   localparam int MPLIER_W   = 32;
   localparam int ALPHA_W    = 17;
   localparam int BAND_W     = 31;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   // multiplicand width with default converter width
   localparam int DEF_MCAND_W = FORCE_W + 1;

   // filter fixed point
   localparam int ALPHA_FRAC = 16;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC);
   localparam int ROUND_HALF = 1 << (ALPHA_FRAC - 1);

   // register reset values
   localparam logic [MPLIER_W-1:0] GAIN_RESET     = 32'd429497;
   localparam logic [ALPHA_W-1:0]  ALPHA_RESET    = 17'd13107;
   localparam logic [BAND_W-1:0]   DEADBAND_RESET = 31'd1966;

   // saturation limits
   localparam logic signed [FORCE_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [FORCE_W-1:0] SAT_MIN = 32'sh8000_0000;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SAMPLE  = 2'd0,
      ACT_CAPTURE = 2'd1,
      ACT_CLEAR   = 2'd2,
      ACT_TARE    = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NEW       = 3'd0,
      STATUS_HELD      = 3'd1,
      STATUS_ZEROED    = 3'd2,
      STATUS_ZERO_FAIL = 3'd3,
      STATUS_CLEARED   = 3'd4
   } status_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ADC_OFFSET   = 2'd0,
      CSR_FORCE_GAIN   = 2'd1,
      CSR_FILTER_ALPHA = 2'd2,
      CSR_DEAD_BAND    = 2'd3
   } csr_index_type;

   // serial multiplier status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

endpackage

// ===== src/lcfc_if.sv =====
// ---------------------------------------------------------------------------
// lcfc channel interfaces
// request, response and register write channels with valid/ready handshake
// ---------------------------------------------------------------------------

// request channel: one converter reading and action per transaction
interface lcfc_req_if import lcfc_pkg::*; #(
   parameter int ADC_BITS = DEF_ADC_BITS
);
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic                       adc_ready;
   logic signed [ADC_BITS-1:0] adc_average;

   modport source (output valid, action, adc_ready, adc_average, input ready);
   modport sink (input valid, action, adc_ready, adc_average, output ready);
endinterface

// response channel: conditioned force and status per transaction
interface lcfc_rsp_if import lcfc_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [FORCE_W-1:0] force_out;
   logic [STATUS_W-1:0]       status;

   modport source (output valid, force_out, status, input ready);
   modport sink (input valid, force_out, status, output ready);
endinterface

// register write channel
interface lcfc_csr_if import lcfc_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

// ===== src/lcfc_serial_mul.sv =====
// ---------------------------------------------------------------------------
// lcfc_serial_mul
// shift-add multiplier, signed multiplicand by unsigned 32-bit multiplier,
// one multiplier bit per cycle with a narrow adder on the high half
// ---------------------------------------------------------------------------
module lcfc_serial_mul import lcfc_pkg::*; #(
   parameter int MCAND_W = DEF_MCAND_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [MCAND_W-1:0]         mcand,
   input  logic [MPLIER_W-1:0]               mplier,
   output mul_stat_type                      stat,
   output logic signed [MCAND_W+MPLIER_W:0]  product
);

   localparam int CNT_W = $clog2(MPLIER_W);

   logic signed [MCAND_W:0]   hi_ff, hi_in;
   logic [MPLIER_W-1:0]       lo_ff, lo_in;
   logic signed [MCAND_W-1:0] md_ff, md_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic signed [MCAND_W:0]   addend;
   logic signed [MCAND_W:0]   sum;

   // partial product add on the high half
   always_comb begin
      addend = lo_ff[0] ? (MCAND_W+1)'(md_ff) : '0;
      sum    = hi_ff + addend;
   end

   // step control and arithmetic right shift of the product pair
   always_comb begin
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      md_in   = md_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         hi_in   = '0;
         lo_in   = mplier;
         md_in   = mcand;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = {sum[MCAND_W], sum[MCAND_W:1]};
         lo_in  = {sum[0], lo_ff[MPLIER_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MPLIER_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      md_ff <= md_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = {hi_ff, lo_ff};

endmodule

// ===== src/load_cell_force_conditioner_top.sv =====
// ---------------------------------------------------------------------------
// load_cell_force_conditioner_top: offset, gain, zero, low-pass, deadband
// paths: held, failed, clear and tare go from idle straight to the output step;
// a zero capture and an unprimed sample take one multiplier pass, a filtered sample two
// requests: one in flight at a time, taken only in idle, paced by the 32-step passes
// of the shared serial multiplier; a stalled response holds the next result back
// reset: synchronous, registers to defaults, zero/filter/last force cleared
// ---------------------------------------------------------------------------
`include "load_cell_force_conditioner_top_defines.svh"

module load_cell_force_conditioner_top import lcfc_pkg::*; #(
   parameter int ADC_BITS  = DEF_ADC_BITS,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic       clock,
   input  logic       reset,
   lcfc_req_if.sink   req_bus,
   lcfc_rsp_if.source rsp_bus,
   lcfc_csr_if.sink   csr_bus
);

   localparam int MCAND_W = (ADC_BITS + 1 > FORCE_W + 1) ? ADC_BITS + 1 : FORCE_W + 1;
   localparam int PROD_W  = MCAND_W + 1 + MPLIER_W;
   localparam int GAIN_SH = MPLIER_W - FRAC_BITS;
   localparam int T_W     = FORCE_W + 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_RAW,
      ST_X,
      ST_D,
      ST_MUL2,
      ST_FILT,
      ST_FUPD,
      ST_DEAD,
      ST_OUT
   } state_type;

   state_type                  state_ff, state_in;
   action_type                 act_ff, act_in;
   logic signed [ADC_BITS-1:0] offset_ff, offset_in;
   logic [MPLIER_W-1:0]        gain_ff, gain_in;
   logic [ALPHA_W-1:0]         alpha_ff, alpha_in;
   logic [BAND_W-1:0]          band_ff, band_in;
   logic signed [FORCE_W-1:0]  zero_ff, zero_in;
   logic signed [FORCE_W-1:0]  filt_ff, filt_in;
   logic                       primed_ff, primed_in;
   logic signed [FORCE_W-1:0]  last_ff, last_in;
   logic signed [FORCE_W-1:0]  raw_ff, raw_in;
   logic signed [FORCE_W-1:0]  x_ff, x_in;
   logic signed [T_W-1:0]      t_ff, t_in;
   logic signed [FORCE_W-1:0]  res_ff, res_in;
   status_type                 stat_ff, stat_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [FORCE_W-1:0]  rsp_force_ff, rsp_force_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;

   logic                       req_fire;
   action_type                 req_action;
   logic                       gain_ok;
   logic signed [ADC_BITS:0]   diff;
   logic signed [FORCE_W:0]    x_wide;
   logic signed [FORCE_W-1:0]  x_sat;
   logic signed [FORCE_W:0]    d_wide;
   logic signed [PROD_W-1:0]   p1_shift;
   logic [PROD_W-FORCE_W:0]    p1_upper;
   logic signed [FORCE_W-1:0]  raw_sat;
   logic signed [PROD_W-1:0]   p2_round;
   logic signed [PROD_W-1:0]   p2_shift;
   logic signed [T_W-1:0]      f_sum;
   logic signed [FORCE_W-1:0]  f_sat;
   logic [FORCE_W-1:0]         f_mag;
   logic                       in_band;
   logic [ALPHA_W-1:0]         alpha_eff;

   logic                       mul_start;
   logic signed [MCAND_W-1:0]  mul_mcand;
   logic [MPLIER_W-1:0]        mul_mplier;
   mul_stat_type               mul_stat;
   logic signed [PROD_W-1:0]   mul_prod;

   // shared serial multiplier
   lcfc_serial_mul #(
      .MCAND_W (MCAND_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .stat    (mul_stat),
      .product (mul_prod)
   );

   // handshakes
   assign req_fire   = req_bus.valid && req_bus.ready;
   assign req_action = action_type'(req_bus.action);
   assign gain_ok    = (gain_ff != '0);

   // reading minus hardware offset
   assign diff = {req_bus.adc_average[ADC_BITS-1], req_bus.adc_average}
               - {offset_ff[ADC_BITS-1], offset_ff};

   // raw force: floor of product shifted to the force format, saturated
   always_comb begin
      p1_shift = mul_prod >>> GAIN_SH;
      p1_upper = p1_shift[PROD_W-1:FORCE_W-1];
      if ((&p1_upper) || !(|p1_upper)) begin
         raw_sat = p1_shift[FORCE_W-1:0];
      end else begin
         raw_sat = p1_shift[PROD_W-1] ? SAT_MIN : SAT_MAX;
      end
   end

   // zeroed force, saturated
   always_comb begin
      x_wide = {raw_ff[FORCE_W-1], raw_ff} - {zero_ff[FORCE_W-1], zero_ff};
      if (x_wide[FORCE_W] != x_wide[FORCE_W-1]) begin
         x_sat = x_wide[FORCE_W] ? SAT_MIN : SAT_MAX;
      end else begin
         x_sat = x_wide[FORCE_W-1:0];
      end
   end

   // filter step: f + floor((alpha * (x - f) + half) / one)
   assign d_wide    = {x_ff[FORCE_W-1], x_ff} - {filt_ff[FORCE_W-1], filt_ff};
   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign p2_round  = mul_prod + PROD_W'(ROUND_HALF);
   assign p2_shift  = p2_round >>> ALPHA_FRAC;

   always_comb begin
      f_sum = T_W'(filt_ff) + t_ff;
      if ((&f_sum[T_W-1:FORCE_W-1]) || !(|f_sum[T_W-1:FORCE_W-1])) begin
         f_sat = f_sum[FORCE_W-1:0];
      end else begin
         f_sat = f_sum[T_W-1] ? SAT_MIN : SAT_MAX;
      end
   end

   // deadband test on the magnitude
   assign f_mag   = filt_ff[FORCE_W-1] ? (~filt_ff + 1'b1) : filt_ff;
   assign in_band = (f_mag < {1'b0, band_ff});

   // multiplier operands: gain pass from idle, alpha pass from the difference step
   always_comb begin
      if (state_ff == ST_D) begin
         mul_mcand  = MCAND_W'(d_wide);
         mul_mplier = MPLIER_W'(alpha_eff);
      end else begin
         mul_mcand  = MCAND_W'(diff);
         mul_mplier = gain_ff;
      end
   end

   // sequencer and next state of all registers
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      offset_in     = offset_ff;
      gain_in       = gain_ff;
      alpha_in      = alpha_ff;
      band_in       = band_ff;
      zero_in       = zero_ff;
      filt_in       = filt_ff;
      primed_in     = primed_ff;
      last_in       = last_ff;
      raw_in        = raw_ff;
      x_in          = x_ff;
      t_in          = t_ff;
      res_in        = res_ff;
      stat_in       = stat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_force_in  = rsp_force_ff;
      rsp_status_in = rsp_status_ff;
      mul_start     = 1'b0;

      // register writes
      if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.addr))
            CSR_ADC_OFFSET:   offset_in = csr_bus.data[ADC_BITS-1:0];
            CSR_FORCE_GAIN:   gain_in   = csr_bus.data[MPLIER_W-1:0];
            CSR_FILTER_ALPHA: alpha_in  = csr_bus.data[ALPHA_W-1:0];
            CSR_DEAD_BAND:    band_in   = csr_bus.data[BAND_W-1:0];
            default:          gain_in   = gain_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               act_in = req_action;
               unique case (req_action)
                  ACT_SAMPLE: begin
                     if (req_bus.adc_ready && gain_ok) begin
                        mul_start = 1'b1;
                        state_in  = ST_MUL1;
                     end else begin
                        res_in   = last_ff;
                        stat_in  = STATUS_HELD;
                        state_in = ST_OUT;
                     end
                  end
                  ACT_CAPTURE: begin
                     if (req_bus.adc_ready && gain_ok) begin
                        mul_start = 1'b1;
                        state_in  = ST_MUL1;
                     end else begin
                        res_in   = last_ff;
                        stat_in  = STATUS_ZERO_FAIL;
                        state_in = ST_OUT;
                     end
                  end
                  ACT_CLEAR: begin
                     zero_in   = '0;
                     filt_in   = '0;
                     primed_in = 1'b0;
                     res_in    = last_ff;
                     stat_in   = STATUS_CLEARED;
                     state_in  = ST_OUT;
                  end
                  ACT_TARE: begin
                     if (req_bus.adc_ready) begin
                        zero_in   = '0;
                        last_in   = '0;
                        filt_in   = '0;
                        primed_in = 1'b0;
                        res_in    = '0;
                        stat_in   = STATUS_CLEARED;
                     end else begin
                        res_in  = last_ff;
                        stat_in = STATUS_ZERO_FAIL;
                     end
                     state_in = ST_OUT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL1: begin
            if (mul_stat.done) begin
               state_in = ST_RAW;
            end
         end
         ST_RAW: begin
            raw_in = raw_sat;
            if (act_ff == ACT_CAPTURE) begin
               zero_in   = raw_sat;
               last_in   = '0;
               filt_in   = '0;
               primed_in = 1'b0;
               res_in    = '0;
               stat_in   = STATUS_ZEROED;
               state_in  = ST_OUT;
            end else begin
               state_in = ST_X;
            end
         end
         ST_X: begin
            x_in     = x_sat;
            state_in = ST_D;
         end
         ST_D: begin
            // first sample since the filter was cleared loads the filter directly
            if (!primed_ff) begin
               filt_in   = x_ff;
               primed_in = 1'b1;
               state_in  = ST_DEAD;
            end else begin
               mul_start = 1'b1;
               state_in  = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if (mul_stat.done) begin
               state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            t_in     = p2_shift[T_W-1:0];
            state_in = ST_FUPD;
         end
         ST_FUPD: begin
            filt_in  = f_sat;
            state_in = ST_DEAD;
         end
         ST_DEAD: begin
            res_in   = in_band ? '0 : filt_ff;
            last_in  = in_band ? '0 : filt_ff;
            stat_in  = STATUS_NEW;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_force_in  = res_ff;
               rsp_status_in = stat_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         offset_ff    <= '0;
         gain_ff      <= GAIN_RESET;
         alpha_ff     <= ALPHA_RESET;
         band_ff      <= DEADBAND_RESET;
         zero_ff      <= '0;
         filt_ff      <= '0;
         primed_ff    <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         act_ff        <= act_in;
         offset_ff     <= offset_in;
         gain_ff       <= gain_in;
         alpha_ff      <= alpha_in;
         band_ff       <= band_in;
         zero_ff       <= zero_in;
         filt_ff       <= filt_in;
         primed_ff     <= primed_in;
         last_ff       <= last_in;
         raw_ff        <= raw_in;
         x_ff          <= x_in;
         t_ff          <= t_in;
         res_ff        <= res_in;
         stat_ff       <= stat_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_force_ff  <= rsp_force_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // port drive
   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign csr_bus.ready     = 1'b1;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.force_out = rsp_force_ff;
   assign rsp_bus.status    = rsp_status_ff;

   // checks
   `LCFC_ASSERT(a_idle_mul_free, clock, reset,
      req_bus.ready |-> !mul_stat.busy, "request taken while multiplier busy")
   `LCFC_ASSERT(a_done_in_wait, clock, reset,
      mul_stat.done |-> (state_ff == ST_MUL1 || state_ff == ST_MUL2),
      "multiplier done outside a wait state")
   `LCFC_ASSERT(a_dead_primed, clock, reset,
      (state_ff == ST_DEAD) |-> primed_ff, "deadband stage with unprimed filter")
   `LCFC_ASSERT_NEXT(a_prime_load, clock, reset, (state_ff == ST_D && !primed_ff),
      (primed_ff && filt_ff == $past(x_ff)), "filter not loaded on first sample")

endmodule
